[src/shmig_pkg.sv]
// Shared constants, face codes and helpers for the hex mesh index generator.
`timescale 1ns / 1ps
package shmig_pkg;

	localparam int CNT_W     = 7;   // cell count and position width
	localparam int IDX_W     = 19;  // vertex index width
	localparam int GXY_W     = 13;  // (nx+1)*(ny+1), up to 65*65
	localparam int FACE_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_CELLS = 64;

	localparam logic [FACE_W-1:0] FACE_Z0   = 3'd0;
	localparam logic [FACE_W-1:0] FACE_ZMAX = 3'd1;
	localparam logic [FACE_W-1:0] FACE_X0   = 3'd2;
	localparam logic [FACE_W-1:0] FACE_XMAX = 3'd3;
	localparam logic [FACE_W-1:0] FACE_Y0   = 3'd4;
	localparam logic [FACE_W-1:0] FACE_YMAX = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

	// Zero counts as one cell, anything above the limit is clamped.
	function automatic logic [CNT_W-1:0] eff_cells(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > CNT_W'(MAX_CELLS)) begin
			r = CNT_W'(MAX_CELLS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[src/structured_hex_mesh_index_generator_unit.sv]
// Structured hexahedral brick index generator, top level.
`timescale 1ns / 1ps
// Each request returns one item: first every hexahedron of the brick (x fastest, then y, then z)
// with its eight vertex indices, then the boundary quads face by face (z0, zmax, x0, xmax, y0,
// ymax) with four indices each; the final quad carries last_item. restart=1 returns the first
// hexahedron. A request is taken every cycle while the pipeline is not stalled; the walk counters step at
// the request stage, the next stage forms the y and z products, and the last stage adds the corner
// offsets into the result register. Cell counts must be written through the configuration channel
// only while no request is in flight (the block does not enforce this) and apply from the next
// request; the walk position is kept, and a position outside the new brick starts the walk again.
module structured_hex_mesh_index_generator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [shmig_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [shmig_pkg::CNT_W-1:0]        cfg_data,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic                               restart,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic                               item_is_quad,
	output logic [shmig_pkg::FACE_W-1:0]       face_number,
	output logic [shmig_pkg::IDX_W-1:0]        corner_0,
	output logic [shmig_pkg::IDX_W-1:0]        corner_1,
	output logic [shmig_pkg::IDX_W-1:0]        corner_2,
	output logic [shmig_pkg::IDX_W-1:0]        corner_3,
	output logic [shmig_pkg::IDX_W-1:0]        corner_4,
	output logic [shmig_pkg::IDX_W-1:0]        corner_5,
	output logic [shmig_pkg::IDX_W-1:0]        corner_6,
	output logic [shmig_pkg::IDX_W-1:0]        corner_7,
	output logic                               last_item
);
	import shmig_pkg::*;

	// configuration
	logic [CNT_W-1:0] cells_x_q, cells_y_q, cells_z_q;
	logic [GXY_W-1:0] gxy_q;
	logic [CNT_W-1:0] new_x, new_y, new_z, gxn, gyn;
	logic [2*CNT_W-1:0] gxy_prod;
	logic cfg_acc;

	// walk state
	logic [CNT_W-1:0] pos_a_q, pos_b_q, pos_c_q;
	logic             quad_q;
	logic [FACE_W-1:0] face_q;

	logic [CNT_W-1:0] nx, ny, nz, gx;
	logic stale, go;
	logic [CNT_W-1:0] ca, cb, cc, inc_a, inc_b, inc_c;
	logic a_end, b_end, c_end;
	logic cquad;
	logic [FACE_W-1:0] cface;
	logic [CNT_W-1:0] na, nb, nc;
	logic nquad;
	logic [FACE_W-1:0] nface;
	logic [CNT_W-1:0] x_sel, y_sel, z_sel;
	logic last_d, face_done;

	// pipeline
	logic req_acc, en1, en2, en3;
	logic valid_s1, valid_s2;
	logic [CNT_W-1:0] x_s1, y_s1, z_s1, x_s2;
	logic quad_s1, quad_s2, last_s1, last_s2;
	logic [FACE_W-1:0] face_s1, face_s2;
	logic [GXY_W-1:0] yg_s2, u_s2, v_s2, u_d, v_d;
	logic [IDX_W-1:0] zg_s2;
	logic [2*CNT_W-1:0] yg_full;
	logic [CNT_W+GXY_W-1:0] zg_full;

	// result
	logic res_valid_q, quad_q_out, last_q_out;
	logic [FACE_W-1:0] face_q_out;
	logic [IDX_W-1:0] corner_q [8];
	logic [IDX_W-1:0] base, c1, c2, c3, up;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;

	assign new_x    = (cfg_index == REG_CELLS_X) ? cfg_data : cells_x_q;
	assign new_y    = (cfg_index == REG_CELLS_Y) ? cfg_data : cells_y_q;
	assign new_z    = (cfg_index == REG_CELLS_Z) ? cfg_data : cells_z_q;
	assign gxn      = eff_cells(new_x) + CNT_W'(1);
	assign gyn      = eff_cells(new_y) + CNT_W'(1);
	assign gxy_prod = (2*CNT_W)'(gxn) * (2*CNT_W)'(gyn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CNT_W'(1);
			cells_y_q <= CNT_W'(1);
			cells_z_q <= CNT_W'(1);
			gxy_q     <= GXY_W'(4);
		end else if (cfg_acc) begin
			// an index beyond the list leaves all counts as they are
			cells_x_q <= new_x;
			cells_y_q <= new_y;
			cells_z_q <= new_z;
			gxy_q     <= gxy_prod[GXY_W-1:0];
		end
	end

	assign nx = eff_cells(cells_x_q);
	assign ny = eff_cells(cells_y_q);
	assign nz = eff_cells(cells_z_q);
	assign gx = nx + CNT_W'(1);

	// stale position (counts changed mid-walk) behaves as a restart
	assign stale = (pos_a_q >= nx) || (pos_b_q >= ny) || (pos_c_q >= nz) ||
	               (quad_q && (face_q > FACE_YMAX));
	assign go    = restart || stale;
	assign ca    = go ? '0 : pos_a_q;
	assign cb    = go ? '0 : pos_b_q;
	assign cc    = go ? '0 : pos_c_q;
	assign cquad = go ? 1'b0 : quad_q;
	assign cface = go ? FACE_Z0 : face_q;
	assign inc_a = ca + CNT_W'(1);
	assign inc_b = cb + CNT_W'(1);
	assign inc_c = cc + CNT_W'(1);
	assign a_end = (inc_a == nx);
	assign b_end = (inc_b == ny);
	assign c_end = (inc_c == nz);

	always_comb begin
		na        = ca;
		nb        = cb;
		nc        = cc;
		nquad     = cquad;
		nface     = cface;
		x_sel     = ca;
		y_sel     = cb;
		z_sel     = cc;
		last_d    = 1'b0;
		face_done = 1'b0;
		if (!cquad) begin
			if (a_end) begin
				na = '0;
				if (b_end) begin
					nb = '0;
					if (c_end) begin
						nc    = '0;
						nquad = 1'b1;
						nface = FACE_Z0;
					end else begin
						nc = inc_c;
					end
				end else begin
					nb = inc_b;
				end
			end else begin
				na = inc_a;
			end
		end else begin
			case (cface)
				FACE_Z0, FACE_ZMAX: begin
					z_sel = (cface == FACE_Z0) ? '0 : nz;
					if (a_end) begin
						na = '0;
						if (b_end) begin
							nb        = '0;
							face_done = 1'b1;
						end else begin
							nb = inc_b;
						end
					end else begin
						na = inc_a;
					end
				end
				FACE_X0, FACE_XMAX: begin
					x_sel = (cface == FACE_X0) ? '0 : nx;
					if (b_end) begin
						nb = '0;
						if (c_end) begin
							nc        = '0;
							face_done = 1'b1;
						end else begin
							nc = inc_c;
						end
					end else begin
						nb = inc_b;
					end
				end
				default: begin
					y_sel  = (cface == FACE_Y0) ? '0 : ny;
					last_d = (cface == FACE_YMAX) && c_end && a_end;
					if (c_end) begin
						nc = '0;
						if (a_end) begin
							na        = '0;
							face_done = 1'b1;
						end else begin
							na = inc_a;
						end
					end else begin
						nc = inc_c;
					end
				end
			endcase
			if (face_done) begin
				if (cface == FACE_YMAX) begin
					// wrap to the first hexahedron
					na    = '0;
					nb    = '0;
					nc    = '0;
					nquad = 1'b0;
					nface = FACE_Z0;
				end else begin
					nface = cface + FACE_W'(1);
				end
			end
		end
	end

	// per-stage flow control: a stage moves when empty or when the next one moves
	assign en3       = !res_valid_q || res_ready;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign req_ready = en1;
	assign req_acc   = req_valid & req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_a_q <= '0;
			pos_b_q <= '0;
			pos_c_q <= '0;
			quad_q  <= 1'b0;
			face_q  <= FACE_Z0;
		end else if (req_acc) begin
			pos_a_q <= na;
			pos_b_q <= nb;
			pos_c_q <= nc;
			quad_q  <= nquad;
			face_q  <= nface;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en1) valid_s1 <= req_acc;
			if (en2) valid_s2 <= valid_s1;
			if (en3) res_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			x_s1    <= x_sel;
			y_s1    <= y_sel;
			z_s1    <= z_sel;
			quad_s1 <= cquad;
			face_s1 <= cquad ? cface : FACE_Z0;
			last_s1 <= last_d;
		end
	end

	// corner steps: corners run base, base+u, base+u+v, base+v
	always_comb begin
		u_d = GXY_W'(1);
		v_d = GXY_W'(gx);
		if (quad_s1) begin
			case (face_s1)
				FACE_Z0: begin
					u_d = GXY_W'(gx);
					v_d = GXY_W'(1);
				end
				FACE_ZMAX: begin
					u_d = GXY_W'(1);
					v_d = GXY_W'(gx);
				end
				FACE_X0: begin
					u_d = gxy_q;
					v_d = GXY_W'(gx);
				end
				FACE_XMAX: begin
					u_d = GXY_W'(gx);
					v_d = gxy_q;
				end
				FACE_Y0: begin
					u_d = GXY_W'(1);
					v_d = gxy_q;
				end
				default: begin
					u_d = gxy_q;
					v_d = GXY_W'(1);
				end
			endcase
		end
	end

	assign yg_full = (2*CNT_W)'(y_s1) * (2*CNT_W)'(gx);
	assign zg_full = (CNT_W+GXY_W)'(z_s1) * (CNT_W+GXY_W)'(gxy_q);

	always_ff @(posedge clk) begin
		if (valid_s1 && en2) begin
			x_s2    <= x_s1;
			yg_s2   <= yg_full[GXY_W-1:0];
			zg_s2   <= zg_full[IDX_W-1:0];
			u_s2    <= u_d;
			v_s2    <= v_d;
			quad_s2 <= quad_s1;
			face_s2 <= face_s1;
			last_s2 <= last_s1;
		end
	end

	assign base = IDX_W'(x_s2) + IDX_W'(yg_s2) + zg_s2;
	assign c1   = base + IDX_W'(u_s2);
	assign c3   = base + IDX_W'(v_s2);
	assign c2   = c1 + IDX_W'(v_s2);
	assign up   = IDX_W'(gxy_q);

	always_ff @(posedge clk) begin
		if (valid_s2 && en3) begin
			corner_q[0] <= base;
			corner_q[1] <= c1;
			corner_q[2] <= c2;
			corner_q[3] <= c3;
			corner_q[4] <= quad_s2 ? '0 : base + up;
			corner_q[5] <= quad_s2 ? '0 : c1 + up;
			corner_q[6] <= quad_s2 ? '0 : c2 + up;
			corner_q[7] <= quad_s2 ? '0 : c3 + up;
			quad_q_out  <= quad_s2;
			face_q_out  <= face_s2;
			last_q_out  <= last_s2;
		end
	end

	assign res_valid    = res_valid_q;
	assign item_is_quad = quad_q_out;
	assign face_number  = face_q_out;
	assign last_item    = last_q_out;
	assign corner_0     = corner_q[0];
	assign corner_1     = corner_q[1];
	assign corner_2     = corner_q[2];
	assign corner_3     = corner_q[3];
	assign corner_4     = corner_q[4];
	assign corner_5     = corner_q[5];
	assign corner_6     = corner_q[6];
	assign corner_7     = corner_q[7];

endmodule

[src/shmig_checker.sv]
// Port-level checker for the hex mesh index generator, bound to the top level.
`timescale 1ns / 1ps
module shmig_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic                            item_is_quad,
	input logic [shmig_pkg::FACE_W-1:0]    face_number,
	input logic [shmig_pkg::IDX_W-1:0]     corner_0,
	input logic [shmig_pkg::IDX_W-1:0]     corner_1,
	input logic [shmig_pkg::IDX_W-1:0]     corner_4,
	input logic [shmig_pkg::IDX_W-1:0]     corner_5,
	input logic [shmig_pkg::IDX_W-1:0]     corner_6,
	input logic [shmig_pkg::IDX_W-1:0]     corner_7,
	input logic                            last_item
);
	import shmig_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(corner_0) && $stable(face_number))
		else $error("stalled result changed");

	// hexahedra carry no face and never end the walk
	a_hex_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !item_is_quad |-> face_number == FACE_Z0 && !last_item)
		else $error("hexahedron with face or last flag");

	// second hexahedron corner is the next vertex along x
	a_hex_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !item_is_quad |-> corner_1 == corner_0 + IDX_W'(1))
		else $error("hexahedron corner step wrong");

	// quads leave the upper layer empty and use a valid face
	a_quad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && item_is_quad |-> corner_4 == '0 && corner_5 == '0 &&
			corner_6 == '0 && corner_7 == '0 && face_number <= FACE_YMAX)
		else $error("quad fields wrong");

	// only a quad on the last face ends the walk
	a_last_face: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_item |-> item_is_quad && face_number == FACE_YMAX)
		else $error("last flag outside final face");

endmodule

bind structured_hex_mesh_index_generator_unit shmig_checker u_shmig_checker (.*);
